>>> src/add_sub_cmp_instruction_decoder_unit_macros.svh
// Assertion macros shared by the decoder RTL.
`ifndef ADD_SUB_CMP_INSTRUCTION_DECODER_UNIT_MACROS_SVH
`define ADD_SUB_CMP_INSTRUCTION_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASCID_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ASCID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/ascid_pkg.sv
// Types, codes and decode functions for the ADD/SUB/CMP instruction decoder.
package ascid_pkg;

  // Operation codes.
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_SUB   = 2'd1;
  localparam logic [1:0] OP_CMP   = 2'd2;
  localparam logic [1:0] OP_OTHER = 2'd3;

  // Instruction form codes.
  localparam logic [1:0] FORM_RM      = 2'd0;
  localparam logic [1:0] FORM_IMM_RM  = 2'd1;
  localparam logic [1:0] FORM_IMM_ACC = 2'd2;
  localparam logic [1:0] FORM_NONE    = 2'd3;

  // Opcode masks and base values.
  localparam logic [7:0] OPC_QUAD_MASK = 8'b1111_1100;
  localparam logic [7:0] OPC_PAIR_MASK = 8'b1111_1110;
  localparam logic [7:0] OPC_BASE_MASK = 8'b1111_1000;
  localparam logic [7:0] OPC_ADD_BASE  = 8'h00;
  localparam logic [7:0] OPC_SUB_BASE  = 8'h28;
  localparam logic [7:0] OPC_CMP_BASE  = 8'h38;
  localparam logic [7:0] OPC_GRP_BASE  = 8'h80;
  localparam logic [7:0] OPC_ADD_ACC   = 8'h04;
  localparam logic [7:0] OPC_SUB_ACC   = 8'h2C;
  localparam logic [7:0] OPC_CMP_ACC   = 8'h3C;

  // Group selector values in the ModRM reg bits.
  localparam logic [2:0] SEL_ADD = 3'd0;
  localparam logic [2:0] SEL_SUB = 3'd5;
  localparam logic [2:0] SEL_CMP = 3'd7;

  // ModRM special values.
  localparam logic [1:0] MOD_NO_DISP = 2'd0;
  localparam logic [1:0] MOD_DISP8   = 2'd1;
  localparam logic [1:0] MOD_DISP16  = 2'd2;
  localparam logic [1:0] MOD_REG     = 2'd3;
  localparam logic [2:0] RM_DIRECT   = 3'b110;

  localparam int RES_W   = 49;
  localparam int TDATA_W = 56;

  // One decoded result; the last member sits in the lowest bits.
  typedef struct packed {
    logic [2:0]  length;
    logic [15:0] immediate;
    logic [15:0] displacement;
    logic [2:0]  rm_field;
    logic [2:0]  reg_field;
    logic [1:0]  mode_field;
    logic        reg_is_dest;
    logic        wide;
    logic [1:0]  form;
    logic [1:0]  operation;
  } result_t;

  // Classify an opcode into one of the three forms, or FORM_NONE.
  function automatic logic [1:0] form_of(input logic [7:0] opc);
    logic [7:0] q;
    logic [7:0] h;
    q = opc & OPC_QUAD_MASK;
    h = opc & OPC_PAIR_MASK;
    if (q == OPC_ADD_BASE || q == OPC_SUB_BASE || q == OPC_CMP_BASE) begin
      return FORM_RM;
    end else if (q == OPC_GRP_BASE) begin
      return FORM_IMM_RM;
    end else if (h == OPC_ADD_ACC || h == OPC_SUB_ACC || h == OPC_CMP_ACC) begin
      return FORM_IMM_ACC;
    end
    return FORM_NONE;
  endfunction

  // Operation taken from the high opcode bits.
  function automatic logic [1:0] base_op(input logic [7:0] opc);
    logic [7:0] b;
    b = opc & OPC_BASE_MASK;
    if (b == OPC_ADD_BASE) return OP_ADD;
    if (b == OPC_SUB_BASE) return OP_SUB;
    if (b == OPC_CMP_BASE) return OP_CMP;
    return OP_OTHER;
  endfunction

  // Number of displacement bytes that follow the ModRM byte.
  function automatic logic [1:0] disp_len(input logic [7:0] opc, input logic [7:0] modrm);
    logic [1:0] md;
    md = modrm[7:6];
    if (form_of(opc) == FORM_IMM_ACC) return 2'd0;
    if (md == MOD_NO_DISP && modrm[2:0] == RM_DIRECT) return 2'd2;
    if (md == MOD_DISP8) return 2'd1;
    if (md == MOD_DISP16) return 2'd2;
    return 2'd0;
  endfunction

  // Number of immediate bytes of the instruction.
  function automatic logic [1:0] imm_len(input logic [7:0] opc);
    logic [1:0] f;
    f = form_of(opc);
    if (f == FORM_IMM_RM) return (opc[0] && !opc[1]) ? 2'd2 : 2'd1;
    if (f == FORM_IMM_ACC) return opc[0] ? 2'd2 : 2'd1;
    return 2'd0;
  endfunction

  // Assemble the result from the collected instruction bytes.
  function automatic result_t build_result(input logic [7:0]  opc,
                                           input logic [7:0]  modrm,
                                           input logic [15:0] disp,
                                           input logic [15:0] imm,
                                           input logic [2:0]  len);
    result_t    r;
    logic [1:0] f;
    r = '0;
    f = form_of(opc);
    if (f == FORM_NONE) begin
      // An unknown opcode reports only its own byte.
      r.operation = OP_OTHER;
      r.length    = len;
    end else begin
      r.immediate = imm;
      if (f == FORM_IMM_RM) begin
        unique case (modrm[5:3])
          SEL_ADD: r.operation = OP_ADD;
          SEL_SUB: r.operation = OP_SUB;
          SEL_CMP: r.operation = OP_CMP;
          default: r.operation = OP_OTHER;
        endcase
        // Byte immediate sign-extended to a word operand.
        if (opc[1] && opc[0]) begin
          r.immediate = {{8{imm[7]}}, imm[7:0]};
        end
      end else begin
        r.operation = base_op(opc);
      end
      r.form        = f;
      r.wide        = opc[0];
      r.reg_is_dest = (f == FORM_RM) ? opc[1] : 1'b0;
      if (f == FORM_IMM_ACC) begin
        r.mode_field = MOD_REG;
        r.reg_field  = 3'd0;
        r.rm_field   = 3'd0;
      end else begin
        r.mode_field = modrm[7:6];
        r.reg_field  = modrm[5:3];
        r.rm_field   = modrm[2:0];
      end
      r.displacement = disp;
      r.length       = len;
    end
    return r;
  endfunction

endpackage

>>> src/add_sub_cmp_instruction_decoder_unit.sv
// Byte-serial decoder for the 16-bit ADD, SUB and CMP instruction forms.
// Takes one instruction byte per cycle; a byte can be accepted every cycle unless a stalled result holds off input.
// A result is valid in the cycle after the last byte of its instruction is accepted.
// A stalled result holds off input; the next byte enters as the result is taken.
// Throughput is one byte per cycle while the receiver is ready.
// Synchronous active-low reset rewinds the parser and empties the output register.
module add_sub_cmp_instruction_decoder_unit
  import ascid_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,   // [7:0] instr_byte
  output logic               out_tvalid,
  input  logic               out_tready,
  // [1:0] operation, [3:2] form, [4] wide, [5] reg_is_dest, [7:6] mode_field,
  // [10:8] reg_field, [13:11] rm_field, [29:14] displacement,
  // [45:30] immediate, [48:46] length, [55:49] zero
  output logic [TDATA_W-1:0] out_tdata
);

`include "add_sub_cmp_instruction_decoder_unit_macros.svh"

  // Parser phases.
  localparam logic [2:0] PH_OPCODE  = 3'd0;
  localparam logic [2:0] PH_MODRM   = 3'd1;
  localparam logic [2:0] PH_DISP_LO = 3'd2;
  localparam logic [2:0] PH_DISP_HI = 3'd3;
  localparam logic [2:0] PH_IMM_LO  = 3'd4;
  localparam logic [2:0] PH_IMM_HI  = 3'd5;

  logic [2:0]  phase_r,  phase_nxt;
  logic [7:0]  opcode_r, opcode_nxt;
  logic [7:0]  modrm_r,  modrm_nxt;
  logic [15:0] disp_r,   disp_nxt;
  logic [15:0] imm_r,    imm_nxt;
  logic [2:0]  bytes_r,  bytes_nxt;
  logic        emit_nxt;
  logic        in_fire;
  logic        out_valid_r;
  result_t     res_r, res_nxt;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  // Next parser state for the incoming byte.
  always_comb begin
    phase_nxt  = phase_r;
    opcode_nxt = opcode_r;
    modrm_nxt  = modrm_r;
    disp_nxt   = disp_r;
    imm_nxt    = imm_r;
    bytes_nxt  = bytes_r + 3'd1;
    emit_nxt   = 1'b0;
    unique case (phase_r)
      PH_MODRM: begin
        modrm_nxt = in_tdata;
        if (disp_len(opcode_r, in_tdata) != 2'd0) begin
          phase_nxt = PH_DISP_LO;
        end else if (imm_len(opcode_r) != 2'd0) begin
          phase_nxt = PH_IMM_LO;
        end else begin
          emit_nxt = 1'b1;
        end
      end
      PH_DISP_LO: begin
        disp_nxt = {8'h00, in_tdata};
        if (disp_len(opcode_r, modrm_r) == 2'd2) begin
          phase_nxt = PH_DISP_HI;
        end else if (imm_len(opcode_r) != 2'd0) begin
          phase_nxt = PH_IMM_LO;
        end else begin
          emit_nxt = 1'b1;
        end
      end
      PH_DISP_HI: begin
        disp_nxt = {in_tdata, disp_r[7:0]};
        if (imm_len(opcode_r) != 2'd0) begin
          phase_nxt = PH_IMM_LO;
        end else begin
          emit_nxt = 1'b1;
        end
      end
      PH_IMM_LO: begin
        imm_nxt = {8'h00, in_tdata};
        if (imm_len(opcode_r) == 2'd2) begin
          phase_nxt = PH_IMM_HI;
        end else begin
          emit_nxt = 1'b1;
        end
      end
      PH_IMM_HI: begin
        imm_nxt  = {in_tdata, imm_r[7:0]};
        emit_nxt = 1'b1;
      end
      default: begin
        // Opcode byte starts a new instruction.
        opcode_nxt = in_tdata;
        modrm_nxt  = 8'h00;
        disp_nxt   = 16'h0000;
        imm_nxt    = 16'h0000;
        bytes_nxt  = 3'd1;
        if (form_of(in_tdata) == FORM_NONE) begin
          phase_nxt = PH_OPCODE;
          emit_nxt  = 1'b1;
        end else if (form_of(in_tdata) == FORM_IMM_ACC) begin
          phase_nxt = PH_IMM_LO;
        end else begin
          phase_nxt = PH_MODRM;
        end
      end
    endcase
    if (emit_nxt) begin
      phase_nxt = PH_OPCODE;
    end
  end

  // Result fields from the state as it stands after this byte.
  always_comb begin
    res_nxt = build_result(opcode_nxt, modrm_nxt, disp_nxt, imm_nxt, bytes_nxt);
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_OPCODE;
      opcode_r <= 8'h00;
      modrm_r  <= 8'h00;
      disp_r   <= 16'h0000;
      imm_r    <= 16'h0000;
      bytes_r  <= 3'd0;
    end else if (in_fire) begin
      phase_r  <= phase_nxt;
      opcode_r <= opcode_nxt;
      modrm_r  <= modrm_nxt;
      disp_r   <= disp_nxt;
      imm_r    <= imm_nxt;
      bytes_r  <= bytes_nxt;
    end
  end

  // Output register: loads on a finishing byte, empties when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && emit_nxt) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit_nxt) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(TDATA_W - RES_W){1'b0}}, res_r};

  // Checks on the parser and the output register.
  `ASCID_ASSERT_NEXT(a_emit_rewinds, in_fire && emit_nxt, phase_r == PH_OPCODE,
                     "phase not reset after result")
  `ASCID_ASSERT_NOW(a_len_range, out_valid_r,
                    res_r.length != 3'd0 && res_r.length <= 3'd6,
                    "result length out of range")
  `ASCID_ASSERT_NOW(a_unknown_len,
                    out_valid_r && res_r.operation == OP_OTHER && res_r.form == FORM_RM,
                    res_r.length == 3'd1, "unknown opcode result longer than one byte")
  `ASCID_ASSERT_NOW(a_mid_instr_count, phase_r != PH_OPCODE, bytes_r != 3'd0,
                    "byte count empty inside an instruction")
  `ASCID_ASSERT_NOW(a_stall_blocks_input, out_valid_r && !out_tready, !in_tready,
                    "input taken while result stalled")

endmodule

>>> tb/add_sub_cmp_instruction_decoder_unit_test.sv
// Self-checking testbench for the byte-serial ADD/SUB/CMP instruction decoder.
`timescale 1ns / 1ps

module add_sub_cmp_instruction_decoder_unit_test;
  import ascid_pkg::*;

  localparam int ITEM_GOAL   = 1450;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;

  localparam logic [7:0] RM_BASES  [3] = '{OPC_ADD_BASE, OPC_SUB_BASE, OPC_CMP_BASE};
  localparam logic [7:0] ACC_BASES [3] = '{OPC_ADD_ACC, OPC_SUB_ACC, OPC_CMP_ACC};
  localparam logic [2:0] GRP_SELS  [3] = '{SEL_ADD, SEL_SUB, SEL_CMP};

  // Parser position of the local decoder copy; PH_DONE marks a finished instruction.
  typedef enum logic [2:0] {
    PH_OPC, PH_MODRM, PH_DISP_LO, PH_DISP_HI, PH_IMM_LO, PH_IMM_HI, PH_DONE
  } parse_phase_t;

  // One instruction byte, optionally with a hand-written expected decode.
  typedef struct {
    logic [7:0] data;
    bit         has_want;
    result_t    want;
  } stim_row_t;

  logic                clk;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [7:0]          in_tdata   = 8'h00;  // [7:0] instr_byte
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  // [1:0] operation, [3:2] form, [4] wide, [5] reg_is_dest, [7:6] mode_field,
  // [10:8] reg_field, [13:11] rm_field, [29:14] displacement,
  // [45:30] immediate, [48:46] length, [55:49] zero
  logic [TDATA_W-1:0]  out_tdata;

  stim_row_t stim[$];
  result_t   pending_decodes[$];
  int        bytes_sent  = 0;
  int        bytes_taken = 0;
  int        decodes_seen = 0;
  int        err_cnt     = 0;

  // State of the local decoder copy.
  parse_phase_t parse_ph  = PH_OPC;
  logic [7:0]   held_opc  = 8'h00;
  logic [7:0]   held_modrm = 8'h00;
  logic [15:0]  disp_acc  = 16'h0000;
  logic [15:0]  imm_acc   = 16'h0000;
  logic [2:0]   byte_cnt  = 3'd0;

  add_sub_cmp_instruction_decoder_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Which of the three instruction forms an opcode starts, if any.
  function automatic logic [1:0] opc_form(input logic [7:0] opc);
    casez (opc)
      8'b0000_00??, 8'b0010_10??, 8'b0011_10??: return FORM_RM;
      8'b1000_00??:                             return FORM_IMM_RM;
      8'b0000_010?, 8'b0010_110?, 8'b0011_110?: return FORM_IMM_ACC;
      default:                                  return FORM_NONE;
    endcase
  endfunction

  // Displacement bytes after the ModRM byte of a reg/mem form.
  function automatic int disp_bytes(input logic [7:0] modrm);
    case (modrm[7:6])
      MOD_NO_DISP: return (modrm[2:0] == RM_DIRECT) ? 2 : 0;
      MOD_DISP8:   return 1;
      MOD_DISP16:  return 2;
      default:     return 0;
    endcase
  endfunction

  // Immediate bytes; the group form takes a word only with W set and S clear.
  function automatic int imm_bytes(input logic [7:0] opc);
    case (opc_form(opc))
      FORM_IMM_RM:  return (opc[1:0] == 2'b01) ? 2 : 1;
      FORM_IMM_ACC: return opc[0] ? 2 : 1;
      default:      return 0;
    endcase
  endfunction

  function automatic parse_phase_t phase_after_disp(input logic [7:0] opc);
    return (imm_bytes(opc) != 0) ? PH_IMM_LO : PH_DONE;
  endfunction

  // Advance the local decoder by one byte; returns the decode when an instruction ends.
  task automatic decode_byte(input logic [7:0] b, output bit done, output result_t r);
    logic [1:0] f;
    logic [2:0] sel;
    done = 1'b0;
    r    = '0;
    case (parse_ph)
      PH_MODRM: begin
        held_modrm = b;
        byte_cnt++;
        parse_ph = (disp_bytes(b) != 0) ? PH_DISP_LO : phase_after_disp(held_opc);
      end
      PH_DISP_LO: begin
        disp_acc = {8'h00, b};
        byte_cnt++;
        parse_ph = (disp_bytes(held_modrm) == 2) ? PH_DISP_HI : phase_after_disp(held_opc);
      end
      PH_DISP_HI: begin
        disp_acc[15:8] = b;
        byte_cnt++;
        parse_ph = phase_after_disp(held_opc);
      end
      PH_IMM_LO: begin
        imm_acc = {8'h00, b};
        byte_cnt++;
        parse_ph = (imm_bytes(held_opc) == 2) ? PH_IMM_HI : PH_DONE;
      end
      PH_IMM_HI: begin
        imm_acc[15:8] = b;
        byte_cnt++;
        parse_ph = PH_DONE;
      end
      default: begin
        held_opc   = b;
        held_modrm = 8'h00;
        disp_acc   = 16'h0000;
        imm_acc    = 16'h0000;
        byte_cnt   = 3'd1;
        case (opc_form(b))
          FORM_NONE:    parse_ph = PH_DONE;
          FORM_IMM_ACC: parse_ph = PH_IMM_LO;
          default:      parse_ph = PH_MODRM;
        endcase
      end
    endcase

    if (parse_ph == PH_DONE) begin
      f          = opc_form(held_opc);
      done       = 1'b1;
      r.length   = byte_cnt;
      parse_ph   = PH_OPC;
      if (f == FORM_NONE) begin
        r.operation = OP_OTHER;
      end else begin
        // The group form picks the operation by ModRM reg; the others by opcode bits 5:3.
        sel = (f == FORM_IMM_RM) ? held_modrm[5:3] : held_opc[5:3];
        case (sel)
          SEL_ADD: r.operation = OP_ADD;
          SEL_SUB: r.operation = OP_SUB;
          SEL_CMP: r.operation = OP_CMP;
          default: r.operation = OP_OTHER;
        endcase
        r.form         = f;
        r.wide         = held_opc[0];
        r.displacement = disp_acc;
        r.immediate    = imm_acc;
        if (f == FORM_RM) begin
          r.reg_is_dest = held_opc[1];
        end
        if (f == FORM_IMM_RM && held_opc[1:0] == 2'b11) begin
          r.immediate = {{8{imm_acc[7]}}, imm_acc[7:0]};
        end
        if (f == FORM_IMM_ACC) begin
          r.mode_field = MOD_REG;
        end else begin
          r.mode_field = held_modrm[7:6];
          r.reg_field  = held_modrm[5:3];
          r.rm_field   = held_modrm[2:0];
        end
      end
    end
  endtask

  function automatic result_t mk_decode(input logic [1:0] op, input logic [1:0] f,
                                        input logic w, input logic d,
                                        input logic [1:0] md, input logic [2:0] rg,
                                        input logic [2:0] rm, input logic [15:0] disp,
                                        input logic [15:0] imm, input logic [2:0] len);
    result_t r;
    r.operation    = op;
    r.form         = f;
    r.wide         = w;
    r.reg_is_dest  = d;
    r.mode_field   = md;
    r.reg_field    = rg;
    r.rm_field     = rm;
    r.displacement = disp;
    r.immediate    = imm;
    r.length       = len;
    return r;
  endfunction

  task automatic push_row(input logic [7:0] b);
    stim.push_back('{b, 1'b0, '0});
  endtask

  // Displacement and immediate bytes lean toward the sign and range edges.
  function automatic logic [7:0] data_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Queue one random instruction: mostly well formed, sometimes cut short or pure noise.
  task automatic queue_instruction();
    logic [7:0] opc;
    logic [7:0] modrm;
    logic [7:0] seq[$];
    int         keep;
    if ($urandom_range(99) < 8) begin
      push_row(8'($urandom_range(255)));
      return;
    end
    case ($urandom_range(2))
      0: begin
        opc = RM_BASES[$urandom_range(2)];
        opc[1:0] = 2'($urandom_range(3));
      end
      1: begin
        opc = OPC_GRP_BASE;
        opc[1:0] = 2'($urandom_range(3));
      end
      default: begin
        opc = ACC_BASES[$urandom_range(2)];
        opc[0] = 1'($urandom_range(1));
      end
    endcase
    seq.push_back(opc);
    if (opc_form(opc) != FORM_IMM_ACC) begin
      modrm[7:6] = 2'($urandom_range(3));
      modrm[5:3] = (opc_form(opc) == FORM_IMM_RM && $urandom_range(3) != 0) ?
                   GRP_SELS[$urandom_range(2)] : 3'($urandom_range(7));
      modrm[2:0] = ($urandom_range(3) == 0) ? RM_DIRECT : 3'($urandom_range(7));
      seq.push_back(modrm);
      repeat (disp_bytes(modrm)) seq.push_back(data_byte());
    end
    repeat (imm_bytes(opc)) seq.push_back(data_byte());
    keep = ($urandom_range(19) == 0) ? $urandom_range(1, seq.size() - 1) : seq.size();
    for (int i = 0; i < keep; i++) begin
      push_row(seq[i]);
    end
  endtask

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      flag_error($sformatf("decode %0d %s: got %0h, expected %0h",
                           decodes_seen, name, got, want));
    end
  endtask

  // Predict on every accepted byte.
  always @(posedge clk) begin
    bit      done;
    result_t r;
    if (rst_n && in_tvalid && in_tready) begin
      decode_byte(in_tdata, done, r);
      if (done) begin
        pending_decodes.push_back(stim[bytes_taken].has_want ? stim[bytes_taken].want : r);
      end
      bytes_taken++;
    end
  end

  // Compare every accepted result with the oldest predicted decode.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[RES_W-1:0];
      if (pending_decodes.size() == 0) begin
        flag_error($sformatf("result %h arrived with no decode pending", out_tdata));
      end else begin
        want = pending_decodes.pop_front();
        check_field("operation",    16'(got.operation),   16'(want.operation));
        check_field("form",         16'(got.form),        16'(want.form));
        check_field("wide",         16'(got.wide),        16'(want.wide));
        check_field("reg_is_dest",  16'(got.reg_is_dest), 16'(want.reg_is_dest));
        check_field("mode_field",   16'(got.mode_field),  16'(want.mode_field));
        check_field("reg_field",    16'(got.reg_field),   16'(want.reg_field));
        check_field("rm_field",     16'(got.rm_field),    16'(want.rm_field));
        check_field("displacement", got.displacement,     want.displacement);
        check_field("immediate",    got.immediate,        want.immediate);
        check_field("length",       16'(got.length),      16'(want.length));
        check_field("padding",      16'(out_tdata[TDATA_W-1:RES_W]), 16'h0000);
      end
      decodes_seen++;
    end
  end

  // Sender: bursts of random length separated by random gaps.
  initial begin : sender
    int burst_left;
    int gap_left;
    burst_left = 0;
    gap_left   = 0;
    wait (rst_n);
    while (bytes_sent < stim.size()) begin
      @(posedge clk);
      if (in_tvalid && in_tready) begin
        bytes_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (bytes_sent == stim.size()) begin
          in_tvalid <= 1'b0;
        end else if (gap_left > 0) begin
          in_tvalid <= 1'b0;
          gap_left--;
        end else begin
          in_tvalid <= 1'b1;
          in_tdata  <= stim[bytes_sent].data;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(2) == 0) ? $urandom_range(1, 6) : 0;
          end
        end
      end
    end
  end

  // Receiver: stalls at a randomly redrawn rate, plus two long hold-offs.
  initial begin : receiver
    int stall_pct;
    int hold_left;
    int rx_cyc;
    stall_pct = 0;
    hold_left = 0;
    rx_cyc    = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      rx_cyc++;
      if (rx_cyc % 200 == 0) begin
        case ($urandom_range(4))
          0, 1:    stall_pct = 0;
          2:       stall_pct = 20;
          3:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      if (rx_cyc == 400 || rx_cyc == 2600) begin
        hold_left = 120;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Run limit.
  initial begin : watchdog
    int cyc;
    cyc = 0;
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Stimulus build, reset and end of run.
  initial begin : main
    stim_row_t dir_tab[$];
    dir_tab = '{
      // Unrecognized opcode decodes alone.
      '{8'hFF, 1'b1, mk_decode(OP_OTHER, FORM_RM, 1'b0, 1'b0, 2'd0, 3'd0, 3'd0,
                               16'h0000, 16'h0000, 3'd1)},
      // Byte immediate to accumulator.
      '{8'h04, 1'b0, '0},
      '{8'h7F, 1'b1, mk_decode(OP_ADD, FORM_IMM_ACC, 1'b0, 1'b0, MOD_REG, 3'd0, 3'd0,
                               16'h0000, 16'h007F, 3'd2)},
      // Word immediate to accumulator.
      '{8'h3D, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h80, 1'b1, mk_decode(OP_CMP, FORM_IMM_ACC, 1'b1, 1'b0, MOD_REG, 3'd0, 3'd0,
                               16'h0000, 16'h8000, 3'd3)},
      // Bad group selector, sign-extended byte immediate to a register.
      '{8'h83, 1'b0, '0},
      '{8'hDF, 1'b0, '0},
      '{8'h80, 1'b1, mk_decode(OP_OTHER, FORM_IMM_RM, 1'b1, 1'b0, MOD_REG, 3'd3, 3'd7,
                               16'h0000, 16'hFF80, 3'd3)},
      // Direct address at its top value.
      '{8'h01, 1'b0, '0}, '{8'h06, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0},
      // Longest instruction: word displacement and word immediate.
      '{8'h81, 1'b0, '0}, '{8'hAE, 1'b0, '0}, '{8'h34, 1'b0, '0}, '{8'h12, 1'b0, '0},
      '{8'hCD, 1'b0, '0}, '{8'hAB, 1'b0, '0},
      // Byte displacement with its top bit set, reg as destination.
      '{8'h3A, 1'b0, '0}, '{8'h7B, 1'b0, '0}, '{8'h80, 1'b0, '0},
      // Byte immediate with S set and W clear stays zero-extended.
      '{8'h82, 1'b0, '0}, '{8'hF8, 1'b0, '0}, '{8'hFF, 1'b0, '0}
    };
    foreach (dir_tab[i]) begin
      stim.push_back(dir_tab[i]);
    end
    while (stim.size() < dir_tab.size() + ITEM_GOAL) begin
      queue_instruction();
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until the predictor has seen every byte, then drain the results.
    wait (bytes_taken == stim.size());
    while (pending_decodes.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
